>>> design/dvtu_pkg.sv
// Shared types and constants for the distance-vector table update block.
package dvtu_pkg;

	// Default number of table slots, one cell per slot.
	localparam int TABLE_DEPTH_DEF = 64;

	// Width of the configuration write data and index.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_LOCAL      = 3'd0,
		ST_IMPROVED   = 3'd1,
		ST_KEPT       = 3'd2,
		ST_INSERTED   = 3'd3,
		ST_FULL       = 3'd4,
		ST_READ_OK    = 3'd5,
		ST_READ_EMPTY = 3'd6
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IFACE_ADDR_0 = 3'd0,
		CFG_IFACE_ADDR_1 = 3'd1,
		CFG_IFACE_ADDR_2 = 3'd2,
		CFG_IFACE_ADDR_3 = 3'd3,
		CFG_IFACE_ENABLE = 3'd4
	} cfg_idx_t;

	// Item kinds.
	localparam logic KIND_ADV  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// One input word.
	typedef struct packed {
		logic        kind;
		logic [31:0] dest_addr;
		logic [7:0]  adv_cost;
		logic [31:0] from_addr;
		logic [31:0] recv_iface_addr;
		logic [5:0]  read_index;
	} cmd_t;

	// One result word.
	typedef struct packed {
		status_t     status;
		logic [5:0]  entry_index;
		logic [31:0] entry_dest;
		logic [31:0] entry_next_hop;
		logic [31:0] entry_iface;
		logic [7:0]  entry_cost;
		logic [6:0]  entry_count;
	} result_t;

	// Token that walks down the chain of cells.
	typedef struct packed {
		logic       active;
		logic       done;
		cmd_t       cmd;
		logic [7:0] hop_cost;
		result_t    res;
	} tok_t;

endpackage

>>> design/dvtu_cell.sv
// One table slot: holds a route entry and processes the passing token.
module dvtu_cell import dvtu_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int IDX         = 0,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic [31:0] dest_q;
	logic [31:0] next_hop_q;
	logic [31:0] iface_q;
	logic [7:0]  cost_q;
	tok_t        tok_q;
	tok_t        tok_d;

	logic slot_valid;
	logic slot_next;
	logic read_hit;
	logic dest_hit;
	logic live;

	assign slot_valid = IDX_C < count;
	assign slot_next  = IDX_C == count;
	assign read_hit   = {26'd0, tok_in.cmd.read_index} == 32'(IDX);
	assign dest_hit   = slot_valid && (dest_q == tok_in.cmd.dest_addr);
	assign live       = tok_in.active && !tok_in.done;

	// Entry storage: updated on an improvement, loaded on an insertion.
	always_ff @(posedge clk) begin
		if (live && tok_in.cmd.kind == KIND_ADV) begin
			if (dest_hit) begin
				if (tok_in.hop_cost < cost_q) begin
					cost_q     <= tok_in.hop_cost;
					next_hop_q <= tok_in.cmd.from_addr;
				end
			end else if (slot_next) begin
				dest_q     <= tok_in.cmd.dest_addr;
				next_hop_q <= tok_in.cmd.from_addr;
				iface_q    <= tok_in.cmd.recv_iface_addr;
				cost_q     <= tok_in.hop_cost;
			end
		end
	end

	// Next token: a slot that claims the token writes its result into it.
	always_comb begin
		tok_d = tok_in;
		if (live) begin
			if (tok_in.cmd.kind == KIND_READ) begin
				if (read_hit) begin
					tok_d.done            = 1'b1;
					tok_d.res.entry_index = tok_in.cmd.read_index;
					if (slot_valid) begin
						tok_d.res.status         = ST_READ_OK;
						tok_d.res.entry_dest     = dest_q;
						tok_d.res.entry_next_hop = next_hop_q;
						tok_d.res.entry_iface    = iface_q;
						tok_d.res.entry_cost     = cost_q;
					end else begin
						tok_d.res.status = ST_READ_EMPTY;
					end
				end
			end else if (dest_hit) begin
				tok_d.done               = 1'b1;
				tok_d.res.entry_index    = 6'(IDX);
				tok_d.res.entry_dest     = dest_q;
				tok_d.res.entry_iface    = iface_q;
				if (tok_in.hop_cost < cost_q) begin
					tok_d.res.status         = ST_IMPROVED;
					tok_d.res.entry_next_hop = tok_in.cmd.from_addr;
					tok_d.res.entry_cost     = tok_in.hop_cost;
				end else begin
					tok_d.res.status         = ST_KEPT;
					tok_d.res.entry_next_hop = next_hop_q;
					tok_d.res.entry_cost     = cost_q;
				end
			end else if (slot_next) begin
				tok_d.done               = 1'b1;
				tok_d.res.status         = ST_INSERTED;
				tok_d.res.entry_index    = 6'(IDX);
				tok_d.res.entry_dest     = tok_in.cmd.dest_addr;
				tok_d.res.entry_next_hop = tok_in.cmd.from_addr;
				tok_d.res.entry_iface    = tok_in.cmd.recv_iface_addr;
				tok_d.res.entry_cost     = tok_in.hop_cost;
			end
		end
	end

	// Token stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> design/distance_vector_table_update_top.sv
// Top level of the distance-vector routing table update block.
//
// One command word is taken when start is high and busy is low. Every command
// walks once down a row of TABLE_DEPTH slot cells, one cell per clock, and its
// result is registered; busy is high from the edge that accepted it until the
// result appears. The next command can be given in the cycle the result
// appears; none is taken while one is in the row. The result is shown on
// result for exactly one cycle with done high and must be taken then, since
// it cannot be held off. Local interface addresses are written through
// wr_en, wr_index and wr_data; the user must write them only while the block
// is idle; the block does not enforce it. Table slots need no clearing after reset.
module distance_vector_table_update_top import dvtu_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output result_t               result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [31:0]      iface_addr_q [4];
	logic [3:0]       iface_enable_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             done_q;
	result_t          result_q;

	tok_t             chain [TABLE_DEPTH + 1];
	logic             accept;
	logic             is_local;
	logic [7:0]       hop_cost;
	tok_t             tail;
	result_t          tail_res;
	logic [CNT_W-1:0] count_next;

	assign accept = start && !busy_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				iface_addr_q[k] <= '0;
			end
			iface_enable_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_IFACE_ADDR_0: iface_addr_q[0] <= wr_data;
				CFG_IFACE_ADDR_1: iface_addr_q[1] <= wr_data;
				CFG_IFACE_ADDR_2: iface_addr_q[2] <= wr_data;
				CFG_IFACE_ADDR_3: iface_addr_q[3] <= wr_data;
				CFG_IFACE_ENABLE: iface_enable_q  <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	// Local destination check against the enabled interface addresses.
	always_comb begin
		is_local = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (iface_enable_q[k] && iface_addr_q[k] == cmd.dest_addr) begin
				is_local = 1'b1;
			end
		end
	end

	// Advertised cost plus one, saturating.
	assign hop_cost = (cmd.adv_cost == 8'hFF) ? 8'hFF : cmd.adv_cost + 8'd1;

	// Launch word for the first cell; a local destination is settled here.
	always_comb begin
		chain[0]          = '0;
		chain[0].active   = accept;
		chain[0].done     = is_local && cmd.kind == KIND_ADV;
		chain[0].cmd      = cmd;
		chain[0].hop_cost = hop_cost;
		chain[0].res.status = ST_LOCAL;
	end

	// Row of slot cells.
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		dvtu_cell #(
			.TABLE_DEPTH (TABLE_DEPTH),
			.IDX         (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (count_q),
			.tok_in  (chain[g]),
			.tok_out (chain[g + 1])
		);
	end

	// Word leaving the last cell: unclaimed means full or read out of range.
	assign tail = chain[TABLE_DEPTH];
	always_comb begin
		if (tail.done) begin
			tail_res = tail.res;
		end else begin
			tail_res = '0;
			if (tail.cmd.kind == KIND_READ) begin
				tail_res.status      = ST_READ_EMPTY;
				tail_res.entry_index = tail.cmd.read_index;
			end else begin
				tail_res.status = ST_FULL;
			end
		end
		count_next = count_q + CNT_W'(tail_res.status == ST_INSERTED);
		tail_res.entry_count = 7'(count_next);
	end

	// Busy flag, entry count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= tail.active;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.active) begin
				busy_q <= 1'b0;
			end
			if (tail.active) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.active) begin
			result_q <= tail_res;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

>>> design/dvtu_checker.sv
// Port-level checks for the distance-vector table update block.
module dvtu_checker import dvtu_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// An accepted word keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted word");

	// A result appears only as a pass ends, and the block is free again then.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without a pass in flight");

	// An inserted route always has a nonzero cost.
	a_insert_cost: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_INSERTED |-> result.entry_cost != 8'd0)
		else $error("inserted route with zero cost");

	// The entry count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(result.entry_count) <= TABLE_DEPTH)
		else $error("entry count beyond table depth");

endmodule

bind distance_vector_table_update_top dvtu_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_dvtu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

>>> tb/distance_vector_table_update_top_tb.sv
// Self-checking testbench for the distance-vector routing table update block.
`timescale 1ns / 1ps

module distance_vector_table_update_top_tb;
	import dvtu_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_GAP        = 90;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  start    = 1'b0;
	logic                  busy;
	cmd_t                  cmd_word = '0;
	logic                  done;
	result_t               result_word;
	logic                  wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data  = '0;

	// Predicted routing table and interface registers.
	logic [31:0] tbl_dest     [TABLE_DEPTH_DEF];
	logic [31:0] tbl_next_hop [TABLE_DEPTH_DEF];
	logic [31:0] tbl_iface    [TABLE_DEPTH_DEF];
	logic [7:0]  tbl_cost     [TABLE_DEPTH_DEF];
	int          tbl_count = 0;
	logic [31:0] iface_model [4] = '{default: 32'h0};
	logic [3:0]  iface_en_model = 4'h0;

	result_t expected_results[$];
	int      fail_count      = 0;
	int      quiet_cycles    = 0;
	int      sender_idle_pct = 0;

	distance_vector_table_update_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd_word),
		.done     (done),
		.result   (result_word),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// True when the address matches an enabled local interface.
	function automatic bit is_local_addr(input logic [31:0] addr);
		for (int k = 0; k < 4; k++) begin
			if (iface_en_model[k] && iface_model[k] == addr) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit in_table(input logic [31:0] addr);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_dest[i] == addr) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Builds one result word; slot contents are shown only when asked for.
	function automatic result_t make_result(input status_t st, input int slot, input bit show);
		result_t r;
		r = '0;
		r.status      = st;
		r.entry_index = slot[5:0];
		if (show) begin
			r.entry_dest     = tbl_dest[slot];
			r.entry_next_hop = tbl_next_hop[slot];
			r.entry_iface    = tbl_iface[slot];
			r.entry_cost     = tbl_cost[slot];
		end
		r.entry_count = 7'(tbl_count);
		return r;
	endfunction

	// Applies one command to the predicted table and returns the result it gives.
	function automatic result_t route_update(input cmd_t c);
		logic [7:0] hop_cost;
		if (c.kind == KIND_READ) begin
			if (int'(c.read_index) < tbl_count) begin
				return make_result(ST_READ_OK, int'(c.read_index), 1'b1);
			end
			return make_result(ST_READ_EMPTY, int'(c.read_index), 1'b0);
		end
		if (is_local_addr(c.dest_addr)) begin
			return make_result(ST_LOCAL, 0, 1'b0);
		end
		// One more hop, saturating at the largest cost.
		hop_cost = (c.adv_cost == 8'hFF) ? 8'hFF : c.adv_cost + 8'd1;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_dest[i] == c.dest_addr) begin
				if (hop_cost < tbl_cost[i]) begin
					tbl_cost[i]     = hop_cost;
					tbl_next_hop[i] = c.from_addr;
					return make_result(ST_IMPROVED, i, 1'b1);
				end
				return make_result(ST_KEPT, i, 1'b1);
			end
		end
		if (tbl_count >= TABLE_DEPTH_DEF) begin
			return make_result(ST_FULL, 0, 1'b0);
		end
		tbl_dest[tbl_count]     = c.dest_addr;
		tbl_next_hop[tbl_count] = c.from_addr;
		tbl_iface[tbl_count]    = c.recv_iface_addr;
		tbl_cost[tbl_count]     = hop_cost;
		tbl_count++;
		return make_result(ST_INSERTED, tbl_count - 1, 1'b1);
	endfunction

	function automatic cmd_t adv_cmd(input logic [31:0] dest, input logic [7:0] cost,
			input logic [31:0] from, input logic [31:0] recv);
		cmd_t c;
		c.kind            = KIND_ADV;
		c.dest_addr       = dest;
		c.adv_cost        = cost;
		c.from_addr       = from;
		c.recv_iface_addr = recv;
		c.read_index      = 6'($urandom);
		return c;
	endfunction

	// Read word; the unused fields carry random bits.
	function automatic cmd_t read_cmd(input int idx);
		cmd_t c;
		c.kind            = KIND_READ;
		c.dest_addr       = $urandom;
		c.adv_cost        = 8'($urandom);
		c.from_addr       = $urandom;
		c.recv_iface_addr = $urandom;
		c.read_index      = idx[5:0];
		return c;
	endfunction

	// An address that is neither local nor already in the table.
	function automatic logic [31:0] fresh_dest();
		logic [31:0] addr;
		do begin
			addr = $urandom;
		end while (is_local_addr(addr) || in_table(addr));
		return addr;
	endfunction

	// Random word, biased toward known destinations and edge costs.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   pick;
		c = adv_cmd($urandom, 8'($urandom), $urandom, $urandom);
		if ($urandom_range(99) < 20) begin
			c.kind = KIND_READ;
			if (tbl_count > 0 && $urandom_range(1) == 0) begin
				c.read_index = 6'($urandom_range(tbl_count - 1));
			end
		end
		pick = $urandom_range(99);
		if (pick < 45 && tbl_count > 0) begin
			c.dest_addr = tbl_dest[$urandom_range(tbl_count - 1)];
		end else if (pick < 60) begin
			c.dest_addr = iface_model[$urandom_range(3)];
		end else if (pick < 66) begin
			c.dest_addr = pick[0] ? 32'hFFFF_FFFF : 32'h0;
		end
		case ($urandom_range(3))
			0: begin
				c.adv_cost = 8'($urandom_range(3));
			end
			1: begin
				c.adv_cost = 8'($urandom_range(255, 250));
			end
			default: begin
			end
		endcase
		return c;
	endfunction

	// Sends one word, idling first at random, and predicts its result once accepted.
	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = $urandom_range(MAX_GAP, 1);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		cmd_word <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.insert(expected_results.size(), route_update(c));
	endtask

	// Lowers start and waits until every expected result has come back.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		if (idx == CFG_IFACE_ENABLE) begin
			iface_en_model = value[3:0];
		end else begin
			iface_model[int'(idx)] = value;
		end
	endtask

	task automatic set_interfaces(input logic [31:0] a0, input logic [31:0] a1,
			input logic [31:0] a2, input logic [31:0] a3, input logic [3:0] en);
		wait_idle();
		write_reg(CFG_IFACE_ADDR_0, a0);
		write_reg(CFG_IFACE_ADDR_1, a1);
		write_reg(CFG_IFACE_ADDR_2, a2);
		write_reg(CFG_IFACE_ADDR_3, a3);
		write_reg(CFG_IFACE_ENABLE, {28'h0, en});
	endtask

	// Reads of an empty table, and a disabled interface address that is not local.
	task automatic test_empty_table();
		send_cmd(read_cmd(0));
		send_cmd(read_cmd(63));
		send_cmd(adv_cmd(32'h0, 8'h00, 32'hFFFF_FFFF, 32'h0));
		send_cmd(read_cmd(0));
		send_cmd(read_cmd(1));
	endtask

	// Enabled interface addresses are ignored; disabled ones are routed.
	task automatic test_local_addresses();
		set_interfaces(32'h0, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0001, 4'b0111);
		send_cmd(adv_cmd(32'h0, 8'h05, $urandom, $urandom));
		send_cmd(adv_cmd(32'hFFFF_FFFF, 8'h05, $urandom, $urandom));
		send_cmd(adv_cmd(32'hC0A8_0001, 8'h05, $urandom, $urandom));
		send_cmd(adv_cmd(32'h0A00_0001, 8'h07, 32'h1234_5678, 32'hC0A8_0001));
		set_interfaces(32'h0, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0001, 4'b1000);
		send_cmd(adv_cmd(32'h0A00_0001, 8'h00, $urandom, $urandom));
		send_cmd(adv_cmd(32'h0, 8'h00, $urandom, $urandom));
	endtask

	// Saturation, equal cost kept, strict improvement, higher cost kept, then reads.
	task automatic test_cost_rules();
		send_cmd(adv_cmd(32'h5A5A_0001, 8'hFF, 32'h0101_0101, 32'h0A00_0002));
		send_cmd(adv_cmd(32'h5A5A_0001, 8'hFE, 32'h0202_0202, 32'h0A00_0003));
		send_cmd(adv_cmd(32'h5A5A_0001, 8'hFD, 32'h0303_0303, 32'h0A00_0004));
		send_cmd(adv_cmd(32'h5A5A_0001, 8'h00, 32'hFFFF_FFFF, 32'h0));
		send_cmd(adv_cmd(32'h5A5A_0001, 8'h00, 32'h0, 32'hFFFF_FFFF));
		send_cmd(adv_cmd(32'h5A5A_0001, 8'h09, $urandom, $urandom));
		send_cmd(adv_cmd(32'hFFFF_FFFF, 8'hFE, 32'h0, 32'hFFFF_FFFF));
		send_cmd(read_cmd(1));
		send_cmd(read_cmd(tbl_count - 1));
		send_cmd(read_cmd(tbl_count));
		send_cmd(read_cmd(63));
	endtask

	task automatic test_random_routes(input int n);
		repeat (n) send_cmd(random_cmd());
	endtask

	// Fills the table, offers new destinations, then reads and re-offers slot 63.
	task automatic test_table_full();
		while (tbl_count < TABLE_DEPTH_DEF) begin
			send_cmd(adv_cmd(fresh_dest(), 8'($urandom), $urandom, $urandom));
		end
		repeat (3) send_cmd(adv_cmd(fresh_dest(), 8'($urandom), $urandom, $urandom));
		send_cmd(read_cmd(TABLE_DEPTH_DEF - 1));
		send_cmd(adv_cmd(tbl_dest[TABLE_DEPTH_DEF - 1], 8'h00, $urandom, $urandom));
	endtask

	// Compares each result word with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word, status %0d", result_word.status);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (result_word.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result_word.status);
					fail_count++;
				end
				if (result_word.entry_index !== want.entry_index) begin
					$error("entry_index: expected %0d, actual %0d",
						want.entry_index, result_word.entry_index);
					fail_count++;
				end
				if (result_word.entry_dest !== want.entry_dest) begin
					$error("entry_dest: expected %h, actual %h",
						want.entry_dest, result_word.entry_dest);
					fail_count++;
				end
				if (result_word.entry_next_hop !== want.entry_next_hop) begin
					$error("entry_next_hop: expected %h, actual %h",
						want.entry_next_hop, result_word.entry_next_hop);
					fail_count++;
				end
				if (result_word.entry_iface !== want.entry_iface) begin
					$error("entry_iface: expected %h, actual %h",
						want.entry_iface, result_word.entry_iface);
					fail_count++;
				end
				if (result_word.entry_cost !== want.entry_cost) begin
					$error("entry_cost: expected %0d, actual %0d",
						want.entry_cost, result_word.entry_cost);
					fail_count++;
				end
				if (result_word.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, result_word.entry_count);
					fail_count++;
				end
			end
		end
	end

	// Ends the run when neither a command nor a result has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("distance_vector_table_update_top test failed");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		sender_idle_pct = 26;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_local_addresses();
		test_cost_rules();

		set_interfaces($urandom, $urandom, $urandom, $urandom, 4'b0101);
		test_random_routes(210);

		sender_idle_pct = 49;
		set_interfaces(tbl_dest[0], $urandom, 32'hFFFF_FFFF, 32'h0, 4'hF);
		test_random_routes(210);
		test_table_full();

		sender_idle_pct = 0;
		set_interfaces(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, $urandom, 4'h0);
		test_random_routes(210);

		wait_idle();
		repeat (TABLE_DEPTH_DEF + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("distance_vector_table_update_top test passed");
		end else begin
			$display("distance_vector_table_update_top test failed");
		end
		$finish;
	end

endmodule
